// File: hw/rtl/bdgs_pkg.sv
// bdgs_pkg: shared types and constants of the binary disk grow/shrink frontier block
// used by the top level; depends on nothing
`timescale 1ns / 1ps

package bdgs_pkg;

  // defaults for the top level parameters
  localparam int MAX_DIM_DEF    = 256;
  localparam int MAX_RADIUS_DEF = 8;

  // signed coordinate width, enough for MAX_DIM up to 4096 plus the window reach
  localparam int COORD_W = 14;

  // field and register widths
  localparam int DIM_REG_W = 9;
  localparam int REACH_W   = 7;
  localparam int POS_W     = 8;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_REACH_SQ    = 2'd2;

  // request types
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_MOD,
    ST_Q_SCAN,
    ST_Q_DRAIN
  } state_t;

endpackage

// File: hw/rtl/binary_disk_grow_shrink_frontier_top.sv
// binary_disk_grow_shrink_frontier_top: membership map with disk frontier queries
// a query scans its window rows one per cycle through the ram read port, folds the last row
// in the drain state and strobes its result; busy drops with the strobe, so a new query is
// taken only after the last result. an in-grid write reads the row, then modifies and writes
// it back; an out-of-grid write is dropped and an out-of-grid query strobes zero flags.
// reset: synchronous; the map ram is then cleared one row per cycle, busy all the while.
// results are strobed on out_valid for one cycle; the receiver cannot stall.
// depends on bdgs_pkg and bdgs_ram
`timescale 1ns / 1ps

module binary_disk_grow_shrink_frontier_top #(
  parameter int MAX_DIM    = bdgs_pkg::MAX_DIM_DEF,
  parameter int MAX_RADIUS = bdgs_pkg::MAX_RADIUS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [bdgs_pkg::POS_W-1:0]  in_col,
  input  logic [bdgs_pkg::POS_W-1:0]  in_row,
  input  logic                        in_member,
  // result channel
  output logic                        out_valid,
  output logic                        out_grow_flag,
  output logic                        out_shrink_flag,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bdgs_pkg::APB_AW-1:0] paddr,
  input  logic [bdgs_pkg::APB_DW-1:0] pwdata,
  output logic [bdgs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CW  = bdgs_pkg::COORD_W;
  localparam int AW  = $clog2(MAX_DIM);
  localparam int WIN = 2 * MAX_RADIUS + 1;
  localparam int DW  = $clog2(MAX_RADIUS + 1) + 1;
  localparam int SQW = 2 * DW;
  localparam int D2W = (SQW + 1 > bdgs_pkg::REACH_W) ? SQW + 1 : bdgs_pkg::REACH_W;

  // configuration registers
  logic [bdgs_pkg::DIM_REG_W-1:0] grid_width_r;
  logic [bdgs_pkg::DIM_REG_W-1:0] grid_height_r;
  logic [bdgs_pkg::REACH_W-1:0]   reach_sq_r;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= bdgs_pkg::DIM_REG_W'(256);
      grid_height_r <= bdgs_pkg::DIM_REG_W'(256);
      reach_sq_r    <= bdgs_pkg::REACH_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bdgs_pkg::REG_GRID_WIDTH:  grid_width_r  <= pwdata[bdgs_pkg::DIM_REG_W-1:0];
        bdgs_pkg::REG_GRID_HEIGHT: grid_height_r <= pwdata[bdgs_pkg::DIM_REG_W-1:0];
        bdgs_pkg::REG_REACH_SQ:    reach_sq_r    <= pwdata[bdgs_pkg::REACH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bdgs_pkg::REG_GRID_WIDTH:  prdata = bdgs_pkg::APB_DW'(grid_width_r);
      bdgs_pkg::REG_GRID_HEIGHT: prdata = bdgs_pkg::APB_DW'(grid_height_r);
      bdgs_pkg::REG_REACH_SQ:    prdata = bdgs_pkg::APB_DW'(reach_sq_r);
      default:                   prdata = '0;
    endcase
  end

  // effective grid size, capped at MAX_DIM
  logic [CW-1:0] gw_ext, gh_ext, w_eff, h_eff;
  assign gw_ext = CW'(grid_width_r);
  assign gh_ext = CW'(grid_height_r);
  assign w_eff  = (gw_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : gw_ext;
  assign h_eff  = (gh_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : gh_ext;

  // control and item registers
  bdgs_pkg::state_t         state_r, state_nxt;
  logic [AW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]            c_r, c_nxt, r_r, r_nxt;
  logic                     bit_r, bit_nxt;
  logic signed [DW-1:0]     dy_r, dy_nxt;
  logic signed [DW-1:0]     chk_dy_r, chk_dy_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic                     self_r, self_nxt;
  logic                     any_mem_r, any_mem_nxt;
  logic                     any_non_r, any_non_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     grow_r, grow_nxt;
  logic                     shrink_r, shrink_nxt;

  // ram ports
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [MAX_DIM-1:0]       ram_wdata, ram_rdata;

  bdgs_ram #(
    .WIDTH (MAX_DIM),
    .DEPTH (MAX_DIM)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic          accept;
  logic [CW-1:0] in_col_ext, in_row_ext;
  logic          in_inb;
  assign accept     = start && !busy;
  assign in_col_ext = CW'(in_col);
  assign in_row_ext = CW'(in_row);
  assign in_inb     = (in_col_ext < w_eff) && (in_row_ext < h_eff);

  // row address of the scan issue and of the row being checked
  logic signed [CW-1:0] y_iss, y_chk;
  assign y_iss = $signed(r_r) + CW'(dy_r);
  assign y_chk = $signed(r_r) + CW'(chk_dy_r);

  // window of the returned row around the query column
  logic [MAX_DIM+2*MAX_RADIUS-1:0] pad_row;
  logic [WIN-1:0]                  win, mask;
  logic [AW-1:0]                   c_idx;
  logic [SQW-1:0]                  dy_sq;
  logic                            row_ok;

  assign c_idx   = c_r[AW-1:0];
  assign pad_row = {{MAX_RADIUS{1'b0}}, ram_rdata, {MAX_RADIUS{1'b0}}};
  assign win     = pad_row[c_idx +: WIN];
  assign dy_sq   = SQW'(SQW'(chk_dy_r) * SQW'(chk_dy_r));
  assign row_ok  = (y_chk >= 0) && (y_chk < $signed(h_eff));

  for (genvar k = 0; k < WIN; k++) begin : g_mask
    localparam int DX  = k - MAX_RADIUS;
    localparam int DX2 = DX * DX;
    logic signed [CW-1:0] x;
    logic [D2W-1:0]       d2;
    assign x       = $signed(c_r) + CW'(DX);
    assign d2      = D2W'(dy_sq) + D2W'(DX2);
    assign mask[k] = row_ok && (x >= 0) && (x < $signed(w_eff))
                     && (d2 <= D2W'(reach_sq_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdgs_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    r_r       <= r_nxt;
    bit_r     <= bit_nxt;
    dy_r      <= dy_nxt;
    chk_dy_r  <= chk_dy_nxt;
    self_r    <= self_nxt;
    any_mem_r <= any_mem_nxt;
    any_non_r <= any_non_nxt;
    grow_r    <= grow_nxt;
    shrink_r  <= shrink_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    c_nxt         = c_r;
    r_nxt         = r_r;
    bit_nxt       = bit_r;
    dy_nxt        = dy_r;
    chk_dy_nxt    = dy_r;
    chk_vld_nxt   = 1'b0;
    self_nxt      = self_r;
    any_mem_nxt   = any_mem_r;
    any_non_nxt   = any_non_r;
    out_valid_nxt = 1'b0;
    grow_nxt      = grow_r;
    shrink_nxt    = shrink_r;
    ram_we        = 1'b0;
    ram_waddr     = r_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = y_iss[AW-1:0];

    // fold the checked row into the accumulators
    if (chk_vld_r) begin
      any_mem_nxt = any_mem_r | (|(win & mask));
      any_non_nxt = any_non_r | (|(~win & mask));
      if (chk_dy_r == '0) begin
        self_nxt = win[MAX_RADIUS];
      end
    end

    unique case (state_r)
      bdgs_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MAX_DIM - 1)) begin
          state_nxt = bdgs_pkg::ST_IDLE;
        end
      end
      bdgs_pkg::ST_IDLE: begin
        if (accept) begin
          c_nxt   = in_col_ext;
          r_nxt   = in_row_ext;
          bit_nxt = in_member;
          if (in_req_type == bdgs_pkg::REQ_WRITE) begin
            if (in_inb) begin
              ram_re    = 1'b1;
              ram_raddr = in_row_ext[AW-1:0];
              state_nxt = bdgs_pkg::ST_WR_MOD;
            end
          end else if (in_inb) begin
            dy_nxt      = DW'(-MAX_RADIUS);
            any_mem_nxt = 1'b0;
            any_non_nxt = 1'b0;
            state_nxt   = bdgs_pkg::ST_Q_SCAN;
          end else begin
            // query off the grid: both flags zero
            out_valid_nxt = 1'b1;
            grow_nxt      = 1'b0;
            shrink_nxt    = 1'b0;
          end
        end
      end
      bdgs_pkg::ST_WR_MOD: begin
        ram_we           = 1'b1;
        ram_wdata        = ram_rdata;
        ram_wdata[c_idx] = bit_r;
        state_nxt        = bdgs_pkg::ST_IDLE;
      end
      bdgs_pkg::ST_Q_SCAN: begin
        ram_re      = 1'b1;
        chk_vld_nxt = 1'b1;
        chk_dy_nxt  = dy_r;
        if (dy_r == DW'(MAX_RADIUS)) begin
          state_nxt = bdgs_pkg::ST_Q_DRAIN;
        end else begin
          dy_nxt = dy_r + DW'(1);
        end
      end
      bdgs_pkg::ST_Q_DRAIN: begin
        out_valid_nxt = 1'b1;
        grow_nxt      = !self_nxt && any_mem_nxt;
        shrink_nxt    = self_nxt && any_non_nxt;
        state_nxt     = bdgs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bdgs_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != bdgs_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_grow_flag   = grow_r;
  assign out_shrink_flag = shrink_r;

  // a result follows only the last scan row or an off-grid query
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == bdgs_pkg::ST_Q_DRAIN)
                  || $past(accept && in_req_type == bdgs_pkg::REQ_QUERY))
    else $error("result strobe without a finished query");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_grow_flag && out_shrink_flag))
    else $error("grow and shrink both set");

  // the map is never read and written in the same cycle
  a_ram_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("ram read and write overlap");

  a_chk_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> (state_r == bdgs_pkg::ST_Q_SCAN) || (state_r == bdgs_pkg::ST_Q_DRAIN))
    else $error("row check outside a query scan");

  a_write_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bdgs_pkg::ST_WR_MOD |-> $past(ram_re) && ($past(state_r) == bdgs_pkg::ST_IDLE))
    else $error("write back without its row read");

endmodule

// File: hw/rtl/bdgs_ram.sv
// bdgs_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module bdgs_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
